>>> design/pfa_pkg.sv
// Package for the physical frame allocator: payload structs, command and status codes, register indices.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;
  localparam int unsigned MaxFramesDef = 1024;
  localparam int unsigned PageBytesDef = 4096;
  localparam int unsigned OwnerBitsDef = 8;

  localparam logic [1:0] CmdAlloc     = 2'd0;
  localparam logic [1:0] CmdFree      = 2'd1;
  localparam logic [1:0] CmdFreeOwner = 2'd2;
  localparam logic [1:0] CmdUnused    = 2'd3;

  localparam logic [2:0] StDone     = 3'd0;
  localparam logic [2:0] StVictim   = 3'd1;
  localparam logic [2:0] StInactive = 3'd2;
  localparam logic [2:0] StNoSpace  = 3'd3;
  localparam logic [2:0] StBelow    = 3'd4;

  localparam logic [1:0] RegFrameCount = 2'd0;
  localparam logic [1:0] RegBase       = 2'd1;
  localparam logic [1:0] RegActive     = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [10:0] page_count;
    logic [7:0]  owner;
    logic        reserved;
    logic [31:0] address;
    logic        swap_ok;
  } req_t;

  typedef struct packed {
    logic [31:0] frame_address;
    logic [2:0]  status;
  } rsp_t;
endpackage
`default_nettype wire

>>> design/physical_frame_allocator.sv
// Physical frame allocator top level: frame table memory and command sequencer.
// Depends on pfa_pkg.
//
//  channel | signals                              | direction
//  cmd     | start_i, busy_o, req_i               | in
//  result  | done_o, rsp_o                        | out (one cycle strobe)
//  config  | cfg_we_i, cfg_idx_i, cfg_wdata_i     | in
//
// After reset a clearing pass writes every table entry, with busy high.
// Allocate: scan up to frame_count entries, each read and then checked,
// then write the run, one entry per cycle; a failed single-page allocate adds a victim
// search of up to one turn, reading and checking each entry. Free reads the head entry
// for its run, then clears each frame of the run; free-owner checks each entry in turn.
// The table is one synchronous memory; the sequencer holds one transaction at a time.
// The receiver cannot stall: done_o rises for exactly one cycle with the result.
`timescale 1ns / 1ps
`default_nettype none
module physical_frame_allocator
  import pfa_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MaxFramesDef,
  parameter int unsigned PAGE_BYTES = PageBytesDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [31:0] cfg_wdata_i
);
  localparam int unsigned OWNER_BITS = OwnerBitsDef;
  localparam int unsigned IW = $clog2(MAX_FRAMES);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned PS = $clog2(PAGE_BYTES);
  localparam int unsigned RW = CW;
  localparam logic [CW-1:0] MaxC = CW'(MAX_FRAMES);

  typedef struct packed {
    logic                  used;
    logic                  res;
    logic [OWNER_BITS-1:0] owner;
    logic [RW-1:0]         run;
  } ent_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN, S_SCANW, S_SET, S_VREAD, S_VCHK,
    S_FREAD, S_FWAIT, S_FRUN, S_OREAD, S_OCHK, S_DONE
  } state_e;

  // memory
  ent_t mem [MAX_FRAMES];
  ent_t rd_q;
  logic          we;
  logic [IW-1:0] waddr, raddr;
  ent_t          wdata;
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // configuration
  logic [10:0] fcnt_q;
  logic [31:0] base_q;
  logic        act_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= 11'd1024; base_q <= '0; act_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFrameCount: fcnt_q <= cfg_wdata_i[10:0];
        RegBase:       base_q <= cfg_wdata_i;
        RegActive:     act_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // effective count, clipped to the table size
  logic [CW-1:0] fc;
  always_comb begin
    if ({21'd0, fcnt_q} >= MAX_FRAMES) fc = MaxC;
    else fc = CW'(fcnt_q);
  end

  state_e        st_q;
  req_t          r_q;
  logic [CW-1:0] i_q, first_q, end_q, k_q;
  logic [IW-1:0] p_q, vp_q;
  logic [CW-1:0] cnt_q;
  logic          prevfree_q;
  rsp_t          rsp_q;
  logic          done_q;

  function automatic logic [31:0] faddr(logic [31:0] b, logic [CW-1:0] idx);
    logic [63:0] a;
    a = {32'd0, b} + ({{(64-CW){1'b0}}, idx} << PS);
    return a[31:0];
  endfunction

  logic [31:0] off;
  logic [31:0] fidx;
  assign off  = req_i.address - base_q;
  assign fidx = off >> PS;

  // status known at accept
  logic [2:0] st_init;
  always_comb begin
    st_init = StDone;
    if (req_i.command == CmdAlloc && !act_q) st_init = StInactive;
    else if (req_i.command == CmdFree && req_i.address < base_q) st_init = StBelow;
  end

  ent_t ent_set;
  always_comb begin
    ent_set.used  = 1'b1;
    ent_set.res   = r_q.reserved;
    ent_set.owner = r_q.reserved ? '0 : r_q.owner[OWNER_BITS-1:0];
    ent_set.run   = (i_q == first_q) ? cnt_q : '0;
  end

  logic free_now;
  assign free_now = !rd_q.used && !rd_q.res;
  logic [CW-1:0] runlen;
  assign runlen = i_q - first_q + 1'b1;
  logic [IW-1:0] pnext;
  assign pnext = ({1'b0, p_q} + 1'b1 >= fc) ? '0 : p_q + 1'b1;

  // memory port control
  always_comb begin
    we = 1'b0; waddr = i_q[IW-1:0]; wdata = '0; raddr = i_q[IW-1:0];
    case (st_q)
      S_CLR:  we = 1'b1;
      S_SET:  begin we = 1'b1; wdata = ent_set; end
      S_VREAD: raddr = p_q;
      S_FRUN: we = (i_q < end_q);
      S_OCHK: we = (rd_q.owner == r_q.owner[OWNER_BITS-1:0]);
      default: ;
    endcase
    if (st_q == S_OCHK) waddr = k_q[IW-1:0];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; i_q <= '0; vp_q <= '0; done_q <= 1'b0;
      r_q <= '0; first_q <= '0; end_q <= '0; k_q <= '0; p_q <= '0;
      cnt_q <= '0; prevfree_q <= 1'b0; rsp_q <= '0;
    end else begin
      done_q <= (st_q == S_DONE);
      case (st_q)
        S_CLR: begin
          i_q <= i_q + 1'b1;
          if (i_q == MaxC - 1'b1) st_q <= S_IDLE;
        end
        S_IDLE: if (start_i) begin
          r_q <= req_i;
          cnt_q <= (req_i.page_count == 0) ? CW'(1) :
                   ((req_i.page_count > MAX_FRAMES) ? MaxC + 1'b1 : CW'(req_i.page_count));
          rsp_q <= '{frame_address: '0, status: st_init};
          i_q <= (req_i.command == CmdFree) ? CW'(fidx) : '0;
          prevfree_q <= 1'b0;
          case (req_i.command)
            CmdAlloc: begin
              if (!act_q) st_q <= S_DONE;
              else if (fc == 0) st_q <= S_SCANW;
              else st_q <= S_SCAN;
            end
            CmdFree: begin
              if (req_i.address < base_q) st_q <= S_DONE;
              else if (fidx >= {{(32-CW){1'b0}}, fc}) st_q <= S_DONE;
              else st_q <= S_FREAD;
            end
            CmdFreeOwner: begin
              if (req_i.owner[OWNER_BITS-1:0] == 0 || fc == 0) st_q <= S_DONE;
              else st_q <= S_OREAD;
            end
            default: st_q <= S_DONE;
          endcase
        end
        // read issued at i_q; check next cycle
        S_SCAN: st_q <= S_SCANW;
        S_SCANW: begin
          if (i_q >= fc) begin
            // not found
            if (cnt_q == 1 && r_q.owner[OWNER_BITS-1:0] != 0 && !r_q.reserved &&
                r_q.swap_ok && fc != 0) begin
              p_q <= ({1'b0, vp_q} < fc) ? vp_q : '0;
              k_q <= '0; st_q <= S_VREAD;
            end else begin
              rsp_q.status <= StNoSpace; st_q <= S_DONE;
            end
          end else if (free_now) begin
            if (!prevfree_q) first_q <= i_q;
            prevfree_q <= 1'b1;
            if ((prevfree_q ? runlen : CW'(1)) >= cnt_q) begin
              i_q <= prevfree_q ? first_q : i_q;
              rsp_q.frame_address <= faddr(base_q, prevfree_q ? first_q : i_q);
              end_q <= (prevfree_q ? first_q : i_q) + cnt_q;
              st_q <= S_SET;
            end else begin
              i_q <= i_q + 1'b1; st_q <= S_SCAN;
            end
          end else begin
            prevfree_q <= 1'b0; i_q <= i_q + 1'b1; st_q <= S_SCAN;
          end
        end
        S_SET: begin
          if (i_q + 1'b1 >= end_q) st_q <= S_DONE;
          i_q <= i_q + 1'b1;
        end
        S_VREAD: st_q <= S_VCHK;
        S_VCHK: begin
          p_q <= pnext;
          if (!rd_q.res && rd_q.owner == r_q.owner[OWNER_BITS-1:0]) begin
            rsp_q <= '{frame_address: faddr(base_q, {1'b0, p_q}), status: StVictim};
            vp_q <= pnext; st_q <= S_DONE;
          end else if (k_q + 1'b1 >= fc) begin
            rsp_q.status <= StNoSpace; vp_q <= pnext; st_q <= S_DONE;
          end else begin
            k_q <= k_q + 1'b1; st_q <= S_VREAD;
          end
        end
        S_FREAD: st_q <= S_FWAIT;
        S_FWAIT: begin
          end_q <= (rd_q.run > fc - i_q) ? fc : i_q + rd_q.run;
          st_q <= S_FRUN;
        end
        S_FRUN: begin
          i_q <= i_q + 1'b1;
          if (i_q + 1'b1 >= end_q) st_q <= S_DONE;
        end
        S_OREAD: begin k_q <= i_q; i_q <= i_q + 1'b1; st_q <= S_OCHK; end
        S_OCHK: begin
          if (k_q + 1'b1 >= fc) st_q <= S_DONE;
          else begin k_q <= i_q; i_q <= i_q + 1'b1; end
        end
        S_DONE: st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (st_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
endmodule
`default_nettype wire

>>> tb/sv/physical_frame_allocator_tb.sv
// Testbench for physical_frame_allocator: directed and random commands, self-checking.
// Depends on pfa_pkg and the physical_frame_allocator RTL.
`timescale 1ns / 1ps
`default_nettype none
module physical_frame_allocator_tb;
  import pfa_pkg::*;

  localparam int unsigned NumFrames = 1024;
  localparam int unsigned PageSize = 4096;
  localparam int unsigned WatchLimit = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  physical_frame_allocator i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .req_i      (req),
    .done_o     (done),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow frame table and registers
  logic        tbl_used [NumFrames];
  logic        tbl_rsvd [NumFrames];
  logic [7:0]  tbl_owner[NumFrames];
  logic [10:0] tbl_run  [NumFrames];
  int unsigned victim_ptr;
  logic [10:0] shadow_count = 11'd1024;
  logic [31:0] shadow_base = '0;
  logic        shadow_active = 1'b0;

  rsp_t        pending_rsp[$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned received = 0;
  int unsigned victims_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap_pct = 33;

  function automatic logic [31:0] frame_addr(int unsigned idx);
    return shadow_base + 32'(idx * PageSize);
  endfunction

  function automatic void clear_entry(int unsigned i);
    tbl_used[i] = 1'b0;
    tbl_rsvd[i] = 1'b0;
    tbl_owner[i] = '0;
    tbl_run[i] = '0;
  endfunction

  // Compute the expected response and update the shadow table
  function automatic rsp_t predict_frame_op(req_t r);
    rsp_t        o;
    int unsigned fc, cnt, first, p, cand, idx, run, stop;
    logic        found, hit;
    o = '0;
    o.status = StDone;
    fc = (shadow_count < NumFrames) ? shadow_count : NumFrames;
    cnt = (r.page_count == 0) ? 1 : r.page_count;
    if (r.command == CmdAlloc) begin
      if (!shadow_active) begin
        o.status = StInactive;
      end else begin
        first = 0;
        found = 1'b0;
        for (int unsigned i = 0; i < fc; i++) begin
          if (!tbl_used[i] && !tbl_rsvd[i]) begin
            if (i == 0 || tbl_used[i-1] || tbl_rsvd[i-1]) first = i;
            if (i - first + 1 >= cnt) begin
              found = 1'b1;
              break;
            end
          end
        end
        if (found) begin
          for (int unsigned i = first; i < first + cnt; i++) begin
            tbl_used[i] = 1'b1;
            tbl_rsvd[i] = r.reserved;
            tbl_owner[i] = r.reserved ? 8'd0 : r.owner;
            tbl_run[i] = (i == first) ? 11'(cnt) : 11'd0;
          end
          o.frame_address = frame_addr(first);
        end else if (cnt == 1 && r.owner != 0 && !r.reserved && r.swap_ok && fc > 0) begin
          p = (victim_ptr < fc) ? victim_ptr : 0;
          hit = 1'b0;
          for (int unsigned k = 0; k < fc; k++) begin
            cand = p;
            p++;
            if (p >= fc) p = 0;
            if (!tbl_rsvd[cand] && tbl_owner[cand] == r.owner) begin
              o.frame_address = frame_addr(cand);
              hit = 1'b1;
              break;
            end
          end
          victim_ptr = p;
          o.status = hit ? StVictim : StNoSpace;
        end else begin
          o.status = StNoSpace;
        end
      end
    end else if (r.command == CmdFree) begin
      if (r.address < shadow_base) begin
        o.status = StBelow;
      end else begin
        idx = (r.address - shadow_base) / PageSize;
        if (idx < fc) begin
          run = tbl_run[idx];
          stop = (run > fc - idx) ? fc : idx + run;
          tbl_run[idx] = '0;
          for (int unsigned i = idx; i < stop; i++) clear_entry(i);
        end
      end
    end else if (r.command == CmdFreeOwner) begin
      if (r.owner != 0) begin
        for (int unsigned i = 0; i < fc; i++)
          if (tbl_owner[i] == r.owner) clear_entry(i);
      end
    end
    return o;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (done) begin
      received++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result addr=%h status=%0d", $time,
                 rsp.frame_address, rsp.status);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp.status == StVictim) victims_seen++;
        if (rsp.frame_address !== exp_rsp.frame_address) begin
          $display("%0t: frame_address expected %h actual %h", $time,
                   exp_rsp.frame_address, rsp.frame_address);
          errors++;
        end
        if (rsp.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_rsp.status, rsp.status);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("physical_frame_allocator test failed");
      $finish;
    end
  end

  // Send one transaction; hold start while the allocator is busy, then drop it
  task automatic send_cmd(req_t r);
    while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(predict_frame_op(r));
    sent++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (3 * NumFrames + 10) @(posedge clk);
  endtask

  // Write a register while idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegFrameCount: shadow_count = val[10:0];
      RegBase:       shadow_base = val;
      RegActive:     shadow_active = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic req_t mk(logic [1:0] c, int unsigned n, logic [7:0] o,
                              logic rs, logic [31:0] a, logic sw);
    req_t r;
    r.command = c;
    r.page_count = 11'(n);
    r.owner = o;
    r.reserved = rs;
    r.address = a;
    r.swap_ok = sw;
    return r;
  endfunction

  // Inactive allocation, free and free-owner while inactive, unused command
  task automatic test_inactive();
    send_cmd(mk(CmdAlloc, 1, 8'd5, 1'b0, '0, 1'b1));
    send_cmd(mk(CmdFree, 1, 8'd0, 1'b0, 32'h0000_0000, 1'b0));
    send_cmd(mk(CmdFreeOwner, 1, 8'd5, 1'b0, '0, 1'b0));
    send_cmd(mk(CmdUnused, 11'h7ff, 8'hff, 1'b1, 32'hffff_ffff, 1'b1));
    wait_drain();
  endtask

  // Directed corners on a tiny table: victims, reserved, free corners
  task automatic test_directed();
    write_reg(RegFrameCount, 32'd4);
    write_reg(RegBase, 32'h0001_0000);
    write_reg(RegActive, 32'd1);
    send_cmd(mk(CmdAlloc, 0, 8'd7, 1'b0, '0, 1'b1));
    send_cmd(mk(CmdAlloc, 2, 8'd0, 1'b1, '0, 1'b0));
    send_cmd(mk(CmdAlloc, 1, 8'd7, 1'b0, '0, 1'b1));
    send_cmd(mk(CmdAlloc, 1, 8'd7, 1'b0, '0, 1'b1));
    send_cmd(mk(CmdAlloc, 1, 8'd7, 1'b0, '0, 1'b1));
    send_cmd(mk(CmdAlloc, 1, 8'd7, 1'b0, '0, 1'b0));
    send_cmd(mk(CmdAlloc, 1, 8'd9, 1'b0, '0, 1'b1));
    send_cmd(mk(CmdAlloc, 1, 8'd7, 1'b1, '0, 1'b1));
    send_cmd(mk(CmdAlloc, 2, 8'd7, 1'b0, '0, 1'b1));
    send_cmd(mk(CmdFree, 1, 8'd0, 1'b0, 32'h0000_ffff, 1'b0));
    send_cmd(mk(CmdFree, 1, 8'd0, 1'b0, 32'h0001_1abc, 1'b0));
    send_cmd(mk(CmdFree, 1, 8'd0, 1'b0, 32'h0001_2000, 1'b0));
    send_cmd(mk(CmdFree, 1, 8'd0, 1'b0, 32'hffff_ffff, 1'b0));
    send_cmd(mk(CmdFreeOwner, 1, 8'd0, 1'b0, '0, 1'b0));
    send_cmd(mk(CmdFreeOwner, 1, 8'd7, 1'b0, '0, 1'b0));
    send_cmd(mk(CmdAlloc, 11'h7ff, 8'hff, 1'b0, '0, 1'b1));
    wait_drain();
    // Zero frames, then shrink below the victim pointer
    write_reg(RegFrameCount, 32'd0);
    send_cmd(mk(CmdAlloc, 1, 8'd3, 1'b0, '0, 1'b1));
    wait_drain();
    write_reg(RegFrameCount, 32'd1);
    send_cmd(mk(CmdAlloc, 1, 8'd3, 1'b0, '0, 1'b1));
    send_cmd(mk(CmdAlloc, 1, 8'd3, 1'b0, '0, 1'b1));
    send_cmd(mk(CmdFree, 1, 8'd0, 1'b0, 32'h0001_0000, 1'b0));
    wait_drain();
    // Full table, largest run, base near the top so addresses wrap
    write_reg(RegFrameCount, 32'h7ff);
    write_reg(RegBase, 32'hfff0_0000);
    send_cmd(mk(CmdAlloc, 1024, 8'h80, 1'b0, '0, 1'b1));
    send_cmd(mk(CmdAlloc, 1, 8'h80, 1'b0, '0, 1'b1));
    send_cmd(mk(CmdFreeOwner, 1, 8'h80, 1'b0, '0, 1'b0));
    wait_drain();
  endtask

  // Random well-formed traffic on a small table, with some noise
  task automatic test_random(int unsigned n, int unsigned frames, logic [31:0] base);
    req_t r;
    write_reg(RegFrameCount, frames);
    write_reg(RegBase, base);
    write_reg(RegActive, 32'd1);
    for (int unsigned k = 0; k < n; k++) begin
      r.owner = 8'($urandom_range(3));
      if ($urandom_range(19) == 0) r.owner = 8'($urandom);
      r.reserved = ($urandom_range(7) == 0);
      r.swap_ok = ($urandom_range(5) != 0);
      r.page_count = ($urandom_range(3) == 0) ? 11'($urandom_range(8))
                                                : 11'd1;
      if ($urandom_range(49) == 0) r.page_count = 11'($urandom);
      r.address = base + 32'($urandom_range(frames + 1) * PageSize);
      if ($urandom_range(4) == 0) r.address = r.address + 32'($urandom_range(4095));
      if ($urandom_range(29) == 0) r.address = $urandom;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: r.command = CmdAlloc;
        5, 6, 7:       r.command = CmdFree;
        8:             r.command = CmdFreeOwner;
        default:       r.command = ($urandom_range(3) == 0) ? CmdUnused : CmdAlloc;
      endcase
      send_cmd(r);
    end
    wait_drain();
  endtask

  initial begin
    for (int unsigned i = 0; i < NumFrames; i++) clear_entry(i);
    victim_ptr = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_inactive();
    test_directed();
    send_gap_pct = 33;
    test_random(170, 16, 32'h0040_0000);
    send_gap_pct = 68;
    test_random(170, 24, 32'h8000_0000);
    send_gap_pct = 0;
    test_random(170, 9, 32'hffff_0000);
    write_reg(RegActive, 32'd0);
    $display("Covered %0d commands, %0d results, %0d victim reports.", sent, received,
             victims_seen);
    $display("Configurations: inactive, zero/one/tiny/full tables, wrapping bases.");
    if (errors == 0) begin
      $display("physical_frame_allocator test passed");
    end else begin
      $display("physical_frame_allocator test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
